@@ src/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int HP_W        = 16;
    localparam int REQ_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int BIT_IDX_W   = 3;

    localparam logic [HP_W-1:0] HP_RESET = 16'd500;

    localparam logic [REQ_W-1:0] REQ_NONE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START = 3'd1;
    localparam logic [REQ_W-1:0] REQ_STOP  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WRITE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd4;

    localparam logic [BIT_IDX_W-1:0] BIT_MSB = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_START_WAIT  = 4'd1,
        PH_START_SETUP = 4'd2,
        PH_START_HOLD  = 4'd3,
        PH_STOP_LOW    = 4'd4,
        PH_STOP_WAIT   = 4'd5,
        PH_STOP_SETUP  = 4'd6,
        PH_STOP_HOLD   = 4'd7,
        PH_BIT_LOW     = 4'd8,
        PH_BIT_WAIT    = 4'd9,
        PH_BIT_HIGH    = 4'd10,
        PH_ACK_LOW     = 4'd11,
        PH_ACK_WAIT    = 4'd12,
        PH_ACK_HIGH    = 4'd13
    } phase_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_ack;
        logic              scl_in;
        logic              sda_in;
    } req_t;

    typedef struct packed {
        logic              scl_low;
        logic              sda_low;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_seen;
    } res_t;

endpackage

@@ src/i2cm_ifs.sv @@
// ----------------------------------------------------------------------------
// i2cm_ifs
// Channel interfaces: tick/command input, per-tick result, config write.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
    import i2cm_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              scl_in;
    logic              sda_in;

    modport source (output valid, req_type, tx_byte, send_ack, scl_in, sda_in,
                    input ready);
    modport sink   (input valid, req_type, tx_byte, send_ack, scl_in, sda_in,
                    output ready);
endinterface

interface i2cm_res_if;
    import i2cm_pkg::*;

    logic              valid;
    logic              ready;
    logic              scl_low;
    logic              sda_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_seen;

    modport source (output valid, scl_low, sda_low, busy_res, done_res, rx_byte,
                    ack_seen, input ready);
    modport sink   (input valid, scl_low, sda_low, busy_res, done_res, rx_byte,
                    ack_seen, output ready);
endinterface

interface i2cm_cfg_if;
    import i2cm_pkg::*;

    logic            valid;
    logic            ready;
    logic [HP_W-1:0] wdata;

    modport source (output valid, wdata, input ready);
    modport sink   (input valid, wdata, output ready);
endinterface

@@ src/i2cm_seq.sv @@
// ----------------------------------------------------------------------------
// i2cm_seq
// Bit sequencer state machine: advances one tick per accepted transaction
// and produces the line drives and status seen after that tick.
// ----------------------------------------------------------------------------
module i2cm_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  i2cm_pkg::req_t             item,
    input  logic [i2cm_pkg::HP_W-1:0]  half_period,
    output i2cm_pkg::res_t             res_next
);
    import i2cm_pkg::*;

    localparam int LIM_W = ((TIMER_WIDTH > HP_W) ? TIMER_WIDTH : HP_W) + 1;

    phase_t                  phase_reg, phase_next;
    logic [REQ_W-1:0]        cmd_reg, cmd_next;
    logic [BIT_IDX_W-1:0]    bit_reg, bit_next;
    logic [BYTE_W-1:0]       shift_reg, shift_next;
    logic [TIMER_WIDTH-1:0]  timer_reg, timer_next;
    logic                    scl_reg, scl_next;
    logic                    sda_reg, sda_next;
    logic                    ackc_reg, ackc_next;
    logic                    ackf_reg, ackf_next;
    logic [BYTE_W-1:0]       rx_reg, rx_next;
    logic                    done;

    logic [HP_W-1:0]         hp_nz;
    logic [LIM_W-1:0]        lim_full;
    logic [LIM_W-1:0]        lim;
    logic                    hit;
    logic                    timed;
    logic [BIT_IDX_W-1:0]    bit_dec;

    // Half period limit: zero acts as one, clip to the timer range
    always_comb
    begin
        hp_nz    = (half_period == '0) ? HP_W'(1) : half_period;
        lim_full = LIM_W'(1) << TIMER_WIDTH;
        lim      = (LIM_W'(hp_nz) > lim_full) ? lim_full : LIM_W'(hp_nz);
        hit      = (LIM_W'(timer_reg) + LIM_W'(1)) >= lim;
        bit_dec  = bit_reg - BIT_IDX_W'(1);
        timed    = phase_reg inside {PH_START_SETUP, PH_START_HOLD, PH_STOP_LOW,
                                     PH_STOP_SETUP, PH_STOP_HOLD, PH_BIT_LOW,
                                     PH_BIT_HIGH, PH_ACK_LOW, PH_ACK_HIGH};
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                case (item.req_type)
                    REQ_START: phase_next = PH_START_WAIT;
                    REQ_STOP:  phase_next = PH_STOP_LOW;
                    REQ_WRITE: phase_next = PH_BIT_LOW;
                    REQ_READ:  phase_next = PH_BIT_LOW;
                    default:   phase_next = PH_IDLE;
                endcase
            end
            PH_START_WAIT:  if (item.scl_in) phase_next = PH_START_SETUP;
            PH_START_SETUP: if (hit) phase_next = PH_START_HOLD;
            PH_START_HOLD:  if (hit) phase_next = PH_IDLE;
            PH_STOP_LOW:    if (hit) phase_next = PH_STOP_WAIT;
            PH_STOP_WAIT:   if (item.scl_in) phase_next = PH_STOP_SETUP;
            PH_STOP_SETUP:  if (hit) phase_next = PH_STOP_HOLD;
            PH_STOP_HOLD:   if (hit) phase_next = PH_IDLE;
            PH_BIT_LOW:     if (hit) phase_next = PH_BIT_WAIT;
            PH_BIT_WAIT:    if (item.scl_in) phase_next = PH_BIT_HIGH;
            PH_BIT_HIGH:
            begin
                if (hit)
                begin
                    phase_next = (bit_reg == '0) ? PH_ACK_LOW : PH_BIT_LOW;
                end
            end
            PH_ACK_LOW:     if (hit) phase_next = PH_ACK_WAIT;
            PH_ACK_WAIT:    if (item.scl_in) phase_next = PH_ACK_HIGH;
            PH_ACK_HIGH:    if (hit) phase_next = PH_IDLE;
            default:        phase_next = PH_IDLE;
        endcase
    end

    // Datapath and line drives
    always_comb
    begin
        cmd_next   = cmd_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        timer_next = timer_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ackc_next  = ackc_reg;
        ackf_next  = ackf_reg;
        rx_next    = rx_reg;
        done       = 1'b0;

        if (timed)
        begin
            timer_next = hit ? '0 : timer_reg + TIMER_WIDTH'(1);
        end

        case (phase_reg)
            PH_IDLE:
            begin
                timer_next = '0;
                case (item.req_type)
                    REQ_START:
                    begin
                        cmd_next = REQ_START;
                        scl_next = 1'b0;
                    end
                    REQ_STOP:
                    begin
                        cmd_next = REQ_STOP;
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                    end
                    REQ_WRITE:
                    begin
                        cmd_next   = REQ_WRITE;
                        shift_next = item.tx_byte;
                        bit_next   = BIT_MSB;
                        scl_next   = 1'b1;
                        sda_next   = ~item.tx_byte[BIT_MSB];
                    end
                    REQ_READ:
                    begin
                        cmd_next   = REQ_READ;
                        ackc_next  = item.send_ack;
                        shift_next = '0;
                        bit_next   = BIT_MSB;
                        scl_next   = 1'b1;
                        sda_next   = 1'b0;
                    end
                    default:
                    begin
                        cmd_next = cmd_reg;
                    end
                endcase
            end
            PH_START_SETUP: if (hit) sda_next = 1'b1;
            PH_START_HOLD:  if (hit) done = 1'b1;
            PH_STOP_LOW:    if (hit) scl_next = 1'b0;
            PH_STOP_SETUP:  if (hit) sda_next = 1'b0;
            PH_STOP_HOLD:   if (hit) done = 1'b1;
            PH_BIT_LOW:     if (hit) scl_next = 1'b0;
            PH_BIT_WAIT:
            begin
                if (item.scl_in && cmd_reg == REQ_READ)
                begin
                    shift_next[bit_reg] = item.sda_in;
                end
            end
            PH_BIT_HIGH:
            begin
                if (hit)
                begin
                    scl_next = 1'b1;
                    if (bit_reg == '0)
                    begin
                        sda_next = (cmd_reg == REQ_READ) ? ackc_reg : 1'b0;
                    end
                    else
                    begin
                        bit_next = bit_dec;
                        sda_next = (cmd_reg == REQ_WRITE) ? ~shift_reg[bit_dec] : 1'b0;
                    end
                end
            end
            PH_ACK_LOW:     if (hit) scl_next = 1'b0;
            PH_ACK_WAIT:
            begin
                if (item.scl_in && cmd_reg == REQ_WRITE)
                begin
                    ackf_next = ~item.sda_in;
                end
            end
            PH_ACK_HIGH:
            begin
                if (hit)
                begin
                    if (cmd_reg == REQ_READ)
                    begin
                        rx_next = shift_reg;
                    end
                    bit_next = BIT_MSB;
                    done     = 1'b1;
                end
            end
            default:
            begin
                timer_next = '0;
            end
        endcase
    end

    // Result of this tick
    always_comb
    begin
        res_next.scl_low  = scl_next;
        res_next.sda_low  = sda_next;
        res_next.busy_res = (phase_next != PH_IDLE);
        res_next.done_res = done;
        res_next.rx_byte  = rx_next;
        res_next.ack_seen = ackf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= REQ_NONE;
            bit_reg   <= BIT_MSB;
            shift_reg <= '0;
            timer_reg <= '0;
            scl_reg   <= 1'b0;
            sda_reg   <= 1'b0;
            ackc_reg  <= 1'b0;
            ackf_reg  <= 1'b0;
            rx_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            timer_reg <= timer_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ackc_reg  <= ackc_next;
            ackf_reg  <= ackf_next;
            rx_reg    <= rx_next;
        end
    end

endmodule

@@ src/i2cm_skid.sv @@
// ----------------------------------------------------------------------------
// i2cm_skid
// Two-entry result buffer with registered ready toward the sequencer.
// ----------------------------------------------------------------------------
module i2cm_skid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  i2cm_pkg::res_t  d,
    output logic            space,
    output logic            q_valid,
    input  logic            q_ready,
    output i2cm_pkg::res_t  q
);
    import i2cm_pkg::*;

    res_t        ent0_reg, ent0_next;
    res_t        ent1_reg, ent1_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    assign space   = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q       = ent0_reg;
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        ent0_next = ent0_reg;
        ent1_next = ent1_reg;
        cnt_next  = cnt_reg;
        case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                begin
                    ent0_next = d;
                end
                else
                begin
                    ent1_next = d;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                ent0_next = ent1_reg;
                cnt_next  = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                // push only happens below two entries, so one entry is being replaced
                ent0_next = d;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

endmodule

@@ src/i2c_master_bit_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit
// Open-drain I2C master: start, stop, write byte and read byte, one tick per
// transaction, with SCL clock stretching.
//
//   port  | role | payload
//   ------+------+----------------------------------------------------------
//   req   | sink | req_type, tx_byte, send_ack, scl_in, sda_in (one tick)
//   rsp   | src  | scl_low, sda_low, busy_res, done_res, rx_byte, ack_seen
//   cfg   | sink | wdata = half_period, always ready
//
// One transaction per cycle while the output buffer has room; its result
// enters the output buffer at the same edge and is offered on rsp from the
// next cycle unless an older result stays buffered. The two-entry output
// buffer keeps req ready while one result waits.
// Reset: sequencer idle, both lines released, half_period 500.
// req.ready drops only when the output buffer holds two results.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    i2cm_req_if.sink    req,
    i2cm_res_if.source  rsp,
    i2cm_cfg_if.sink    cfg
);
    import i2cm_pkg::*;

    logic [HP_W-1:0]  half_period_reg;
    logic             fire;
    logic             space;
    req_t             item;
    res_t             res_next;
    res_t             res_q;

    assign req.ready = space;
    assign fire      = req.valid && space;
    assign cfg.ready = 1'b1;

    assign item.req_type = req.req_type;
    assign item.tx_byte  = req.tx_byte;
    assign item.send_ack = req.send_ack;
    assign item.scl_in   = req.scl_in;
    assign item.sda_in   = req.sda_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HP_RESET;
        end
        else if (cfg.valid)
        begin
            half_period_reg <= cfg.wdata;
        end
    end

    i2cm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (item),
        .half_period (half_period_reg),
        .res_next    (res_next)
    );

    i2cm_skid u_skid (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fire),
        .d       (res_next),
        .space   (space),
        .q_valid (rsp.valid),
        .q_ready (rsp.ready),
        .q       (res_q)
    );

    assign rsp.scl_low  = res_q.scl_low;
    assign rsp.sda_low  = res_q.sda_low;
    assign rsp.busy_res = res_q.busy_res;
    assign rsp.done_res = res_q.done_res;
    assign rsp.rx_byte  = res_q.rx_byte;
    assign rsp.ack_seen = res_q.ack_seen;

    // A finishing tick never reports busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_next.done_res |-> !res_next.busy_res)
        else $error("done reported while still busy");

    // Every command ends with SCL released
    a_done_scl_free: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_next.done_res |-> !res_next.scl_low)
        else $error("command finished with SCL held low");

    // With nothing buffered the input side must be open
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp.valid |-> req.ready)
        else $error("input stalled with empty output buffer");

    // A tick taken with no room would lose a result
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready && !req.ready |=> rsp.valid)
        else $error("buffered result dropped while stalled");

endmodule

@@ dv/i2c_master_bit_sequencer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit_tb
// Self-checking bench for the I2C master bit sequencer. Every tick sent on
// req runs through a cycle-level model of the sequencer kept in a scoreboard.
// Each result on rsp is compared field by field with the oldest predicted
// one. A small bus model answers SCL from its predicted drive and stretches
// it at random; SDA is random. The run covers start, stop, write and read
// framing, unused and mistimed codes, and half periods from 0 up to 65535.
// Both channels idle at random, apart from one long stretch without idling.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam int SETTLE_CYCLES = 6;

    class seq_scoreboard;
        logic [HP_W-1:0]        half_period;
        phase_t                 ph;
        logic [REQ_W-1:0]       cmd;
        logic [BIT_IDX_W-1:0]   bit_idx;
        logic [BYTE_W-1:0]      shift_q;
        logic [TIMER_WIDTH-1:0] half_timer;
        logic                   scl_drv;
        logic                   sda_drv;
        logic                   ack_choice;
        logic                   ack_flag;
        logic [BYTE_W-1:0]      rx_data;
        res_t                   pending_outputs[$];
        int                     mismatches;
        int                     checked;

        function new();
            reset_state();
            mismatches = 0;
            checked = 0;
        endfunction

        function void reset_state();
            half_period = HP_RESET;
            ph = PH_IDLE;
            cmd = REQ_NONE;
            bit_idx = BIT_MSB;
            shift_q = '0;
            half_timer = '0;
            scl_drv = 1'b0;
            sda_drv = 1'b0;
            ack_choice = 1'b0;
            ack_flag = 1'b0;
            rx_data = '0;
        endfunction

        // Zero counts as one tick per half period.
        function bit half_done();
            int unsigned lim;
            lim = (half_period == 0) ? 1 : half_period;
            if (half_timer + 32'd1 >= lim)
            begin
                half_timer = '0;
                return 1'b1;
            end
            half_timer = half_timer + 1'b1;
            return 1'b0;
        endfunction

        function void enter_bit_low();
            scl_drv = 1'b1;
            sda_drv = (cmd == REQ_WRITE) ? ~shift_q[bit_idx] : 1'b0;
            half_timer = '0;
            ph = PH_BIT_LOW;
        endfunction

        function void predict_tick(logic [REQ_W-1:0] rq, logic [BYTE_W-1:0] txb,
                                   logic sack, logic scl, logic sda);
            res_t want;
            logic done;
            done = 1'b0;
            case (ph)
                PH_IDLE:
                begin
                    half_timer = '0;
                    if (rq == REQ_START)
                    begin
                        cmd = rq;
                        scl_drv = 1'b0;
                        ph = PH_START_WAIT;
                    end
                    else if (rq == REQ_STOP)
                    begin
                        cmd = rq;
                        scl_drv = 1'b1;
                        sda_drv = 1'b1;
                        ph = PH_STOP_LOW;
                    end
                    else if (rq == REQ_WRITE)
                    begin
                        cmd = rq;
                        shift_q = txb;
                        bit_idx = BIT_MSB;
                        enter_bit_low();
                    end
                    else if (rq == REQ_READ)
                    begin
                        cmd = rq;
                        ack_choice = sack;
                        shift_q = '0;
                        bit_idx = BIT_MSB;
                        enter_bit_low();
                    end
                end
                PH_START_WAIT:
                    if (scl)
                        ph = PH_START_SETUP;
                PH_START_SETUP:
                    if (half_done())
                    begin
                        sda_drv = 1'b1;
                        ph = PH_START_HOLD;
                    end
                PH_START_HOLD:
                    if (half_done())
                    begin
                        ph = PH_IDLE;
                        done = 1'b1;
                    end
                PH_STOP_LOW:
                    if (half_done())
                    begin
                        scl_drv = 1'b0;
                        ph = PH_STOP_WAIT;
                    end
                PH_STOP_WAIT:
                    if (scl)
                        ph = PH_STOP_SETUP;
                PH_STOP_SETUP:
                    if (half_done())
                    begin
                        sda_drv = 1'b0;
                        ph = PH_STOP_HOLD;
                    end
                PH_STOP_HOLD:
                    if (half_done())
                    begin
                        ph = PH_IDLE;
                        done = 1'b1;
                    end
                PH_BIT_LOW:
                    if (half_done())
                    begin
                        scl_drv = 1'b0;
                        ph = PH_BIT_WAIT;
                    end
                PH_BIT_WAIT:
                    if (scl)
                    begin
                        if (cmd == REQ_READ)
                            shift_q[bit_idx] = sda;
                        ph = PH_BIT_HIGH;
                    end
                PH_BIT_HIGH:
                    if (half_done())
                    begin
                        if (bit_idx == 0)
                        begin
                            scl_drv = 1'b1;
                            sda_drv = (cmd == REQ_READ) ? ack_choice : 1'b0;
                            ph = PH_ACK_LOW;
                        end
                        else
                        begin
                            bit_idx = bit_idx - 1'b1;
                            enter_bit_low();
                        end
                    end
                PH_ACK_LOW:
                    if (half_done())
                    begin
                        scl_drv = 1'b0;
                        ph = PH_ACK_WAIT;
                    end
                PH_ACK_WAIT:
                    if (scl)
                    begin
                        if (cmd == REQ_WRITE)
                            ack_flag = ~sda;
                        ph = PH_ACK_HIGH;
                    end
                PH_ACK_HIGH:
                    if (half_done())
                    begin
                        if (cmd == REQ_READ)
                            rx_data = shift_q;
                        bit_idx = BIT_MSB;
                        ph = PH_IDLE;
                        done = 1'b1;
                    end
                default:
                begin
                    ph = PH_IDLE;
                    half_timer = '0;
                end
            endcase
            want.scl_low = scl_drv;
            want.sda_low = sda_drv;
            want.busy_res = (ph != PH_IDLE);
            want.done_res = done;
            want.rx_byte = rx_data;
            want.ack_seen = ack_flag;
            pending_outputs.push_back(want);
        endfunction

        function void match_result(res_t got);
            res_t want;
            bit bad;
            if (pending_outputs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result with nothing outstanding: %p", $realtime, got);
                return;
            end
            want = pending_outputs.pop_front();
            checked++;
            bad = 1'b0;
            bad |= (got.scl_low !== want.scl_low);
            bad |= (got.sda_low !== want.sda_low);
            bad |= (got.busy_res !== want.busy_res);
            bad |= (got.done_res !== want.done_res);
            bad |= (got.rx_byte !== want.rx_byte);
            bad |= (got.ack_seen !== want.ack_seen);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"[%0t] mismatch on result %0d: expected scl=%b sda=%b busy=%b",
                              " done=%b rx=%02h ack=%b, got scl=%b sda=%b busy=%b done=%b",
                              " rx=%02h ack=%b"},
                             $realtime, checked - 1,
                             want.scl_low, want.sda_low, want.busy_res, want.done_res,
                             want.rx_byte, want.ack_seen,
                             got.scl_low, got.sda_low, got.busy_res, got.done_res,
                             got.rx_byte, got.ack_seen);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    i2cm_req_if req_ch();
    i2cm_res_if rsp_ch();
    i2cm_cfg_if cfg_ch();

    i2c_master_bit_sequencer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    seq_scoreboard sb = new();

    bit calm;
    int stretch_pct;
    int tick_count;
    int hold_tick;
    int code_count[8];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("i2c_master_bit_sequencer_unit_tb: FAIL");
        $finish;
    end

    always @(negedge clk)
        rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 31);

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.scl_low = rsp_ch.scl_low;
            got.sda_low = rsp_ch.sda_low;
            got.busy_res = rsp_ch.busy_res;
            got.done_res = rsp_ch.done_res;
            got.rx_byte = rsp_ch.rx_byte;
            got.ack_seen = rsp_ch.ack_seen;
            sb.match_result(got);
        end
    end

    // Released SCL reads high unless a slave stretches it.
    function logic bus_scl();
        if (sb.scl_drv)
            return ($urandom_range(0, 19) == 0);
        return ($urandom_range(0, 99) >= stretch_pct);
    endfunction

    task wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task drive_tick(logic [REQ_W-1:0] rq, logic [BYTE_W-1:0] txb, logic sack,
                    logic scl, logic sda);
        if (tick_count == hold_tick)
            wait_drained();
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rq;
        req_ch.tx_byte <= txb;
        req_ch.send_ack <= sack;
        req_ch.scl_in <= scl;
        req_ch.sda_in <= sda;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.predict_tick(rq, txb, sack, scl, sda);
        tick_count++;
    endtask

    // Send empty ticks without waiting for a command in progress to finish.
    task run_idle_ticks(int n);
        repeat (n)
            drive_tick(REQ_NONE, 8'h00, 1'b0, bus_scl(), 1'($urandom_range(0, 1)));
    endtask

    // Issue one code, then tick until the sequencer is idle again.
    task run_cmd(logic [REQ_W-1:0] rq, logic [BYTE_W-1:0] txb, logic sack, bit noisy);
        logic [REQ_W-1:0] filler;
        code_count[rq]++;
        drive_tick(rq, txb, sack, bus_scl(), 1'($urandom_range(0, 1)));
        while (sb.ph != PH_IDLE)
        begin
            filler = (noisy && $urandom_range(0, 9) == 0) ? REQ_W'($urandom_range(0, 7))
                                                          : REQ_NONE;
            drive_tick(filler, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       bus_scl(), 1'($urandom_range(0, 1)));
        end
    endtask

    task write_half_period(logic [HP_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.wdata <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.half_period = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly whole frames with random content; a tenth of the codes are noise.
    task run_random(int n_ticks);
        logic [REQ_W-1:0] frame[$];
        logic [REQ_W-1:0] nxt;
        int stop_at;
        int k;
        stop_at = tick_count + n_ticks;
        while (tick_count < stop_at)
        begin
            if (frame.size() == 0)
            begin
                frame.push_back(REQ_START);
                k = $urandom_range(1, 3);
                repeat (k) frame.push_back(($urandom_range(0, 1) != 0) ? REQ_WRITE : REQ_READ);
                frame.push_back(REQ_STOP);
            end
            if ($urandom_range(0, 9) == 0)
                nxt = REQ_W'($urandom_range(0, 7));
            else
                nxt = frame.pop_front();
            run_cmd(nxt, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 4) == 0);
        end
    endtask

    initial
    begin
        int guard;
        int leftover;
        rst_n = 1'b0;
        calm = 1'b0;
        stretch_pct = 25;
        tick_count = 0;
        hold_tick = -1;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_NONE;
        req_ch.tx_byte = '0;
        req_ch.send_ack = 1'b0;
        req_ch.scl_in = 1'b1;
        req_ch.sda_in = 1'b1;
        cfg_ch.valid = 1'b0;
        cfg_ch.wdata = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default half period out of reset: open a start and leave it mid-way.
        code_count[REQ_START]++;
        drive_tick(REQ_START, 8'h00, 1'b0, bus_scl(), 1'b1);
        run_idle_ticks(40);

        // Zero half period: finish that start, then directed framing and corner codes.
        write_half_period(16'd0);
        run_cmd(REQ_NONE, 8'h00, 1'b0, 1'b0);
        run_cmd(3'd5, 8'hFF, 1'b1, 1'b0);
        run_cmd(3'd6, 8'h00, 1'b0, 1'b0);
        run_cmd(3'd7, 8'hFF, 1'b1, 1'b0);
        run_cmd(REQ_NONE, 8'hFF, 1'b1, 1'b0);
        run_cmd(REQ_START, 8'h00, 1'b0, 1'b1);
        run_cmd(REQ_WRITE, 8'h00, 1'b1, 1'b1);
        run_cmd(REQ_WRITE, 8'hFF, 1'b0, 1'b1);
        stretch_pct = 90;
        run_cmd(REQ_WRITE, 8'h5A, 1'b0, 1'b0);
        stretch_pct = 25;
        run_cmd(REQ_READ, 8'hFF, 1'b1, 1'b1);
        run_cmd(REQ_READ, 8'h00, 1'b0, 1'b1);
        run_cmd(REQ_START, 8'h00, 1'b0, 1'b0);
        run_cmd(REQ_READ, 8'h00, 1'b0, 1'b0);
        run_cmd(REQ_STOP, 8'h00, 1'b0, 1'b1);
        run_cmd(REQ_STOP, 8'h00, 1'b0, 1'b0);

        // Longest half period: open a start, then finish it at one tick per half.
        write_half_period(16'hFFFF);
        code_count[REQ_START]++;
        drive_tick(REQ_START, 8'h00, 1'b0, bus_scl(), 1'b1);
        run_idle_ticks(40);
        write_half_period(16'd1);
        run_cmd(REQ_NONE, 8'h00, 1'b0, 1'b0);

        hold_tick = tick_count + 250;
        run_random(450);
        write_half_period(16'd2);
        run_random(350);
        write_half_period(HP_W'($urandom_range(3, 6)));
        run_random(350);
        write_half_period(16'd1);
        calm = 1'b1;
        run_random(300);
        calm = 1'b0;

        guard = 0;
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending_outputs.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        leftover = sb.pending_outputs.size();

        $display("covered %0d ticks, %0d results checked, %0d mismatches, %0d left over",
                 tick_count, sb.checked, sb.mismatches, leftover);
        $display("codes: start %0d stop %0d write %0d read %0d, empty or unused %0d",
                 code_count[REQ_START], code_count[REQ_STOP], code_count[REQ_WRITE],
                 code_count[REQ_READ],
                 code_count[REQ_NONE] + code_count[5] + code_count[6] + code_count[7]);
        if (sb.mismatches == 0 && leftover == 0)
            $display("i2c_master_bit_sequencer_unit_tb: PASS");
        else
            $display("i2c_master_bit_sequencer_unit_tb: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
src/i2cm_pkg.sv
src/i2cm_ifs.sv
src/i2cm_seq.sv
src/i2cm_skid.sv
src/i2c_master_bit_sequencer_unit.sv
dv/i2c_master_bit_sequencer_unit_tb.sv
